// ===== hw/rtl/running_block_average_error_unit_macros.svh =====
// Assertion macros used by the running block average checker.
`ifndef RUNNING_BLOCK_AVERAGE_ERROR_UNIT_MACROS_SVH
`define RUNNING_BLOCK_AVERAGE_ERROR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBAE_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbae assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBAE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbae assertion failed");

`endif

// ===== hw/rtl/rbae_pkg.sv =====
// Constants and types of the running block average and error unit.
package rbae_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int COUNT_OUT_W = 11;
  localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W       = DATA_W + $clog2(MAX_BLOCKS);
  // Q16.32 variance stays below 2^(DATA_W + FRAC_W)
  localparam int VAR_W       = DATA_W + FRAC_W;
  localparam int ROOT_W      = VAR_W / 2;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int DIV_STEP    = 4;
  localparam int DIV_NUM_W   = ((SUM_W > VAR_W ? SUM_W : VAR_W) + DIV_STEP - 1)
                               / DIV_STEP * DIV_STEP;
  localparam int DIV_CYC     = DIV_NUM_W / DIV_STEP;
  localparam int DIV_CNT_W   = $clog2(DIV_CYC + 1);
  localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MUL,
    ST_VAR,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_SQRT_WAIT,
    ST_DONE
  } rbae_state_e;

endpackage

// ===== hw/rtl/rbae_div.sv =====
// Iterative unsigned divider, DIV_STEP quotient bits per cycle.
module rbae_div import rbae_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [CNT_W-1:0]     den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o,
  output logic [CNT_W-1:0]     rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] acc_q, acc_d, acc_s;
  logic [CNT_W-1:0]     rem_q, rem_d, rem_s;
  logic [CNT_W-1:0]     den_q, den_d;
  logic [CNT_W:0]       rem_t;

  // Shift dividend bits out of acc and quotient bits in at the bottom
  always_comb begin
    rem_s = rem_q;
    acc_s = acc_q;
    rem_t = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      rem_t = {rem_s, acc_s[DIV_NUM_W-1]};
      acc_s = {acc_s[DIV_NUM_W-2:0], 1'b0};
      if (rem_t >= {1'b0, den_q}) begin
        rem_t    = rem_t - {1'b0, den_q};
        acc_s[0] = 1'b1;
      end
      rem_s = rem_t[CNT_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_CYC);
      acc_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      acc_d = acc_s;
      rem_d = rem_s;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/rbae_sqrt.sv =====
// Iterative integer square root, one root bit per cycle.
module rbae_sqrt import rbae_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [VAR_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic [VAR_W-1:0]      rad_q, rad_d;
  logic [ROOT_W+1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_W+3:0]     rem_t, trial;

  // Bring down two radicand bits, try root*4+1
  assign rem_t = {rem_q, rad_q[VAR_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = SQRT_CNT_W'(ROOT_W);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[VAR_W-3:0], 2'b00};
      cnt_d = cnt_q - 1'b1;
      if (rem_t >= trial) begin
        rem_d  = (ROOT_W+2)'(rem_t - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_t[ROOT_W+1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == SQRT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/running_block_average_error_unit.sv =====
// Running block average and standard error unit: top level with sequencer.
//
// Each accepted beat adds one block's mean and mean of squares (Q16.16) to
// running sums and returns the cumulative mean and its standard error
// sqrt((mean2 - mean^2) / (n - 1)), zero for a single block. first_block_i
// restarts the series. Once MAX_BLOCKS blocks are in the sums, further beats
// without first_block_i are refused and repeat the last result with
// count_full_o set. The unit takes one beat at a time. A full update uses the
// divider (4 quotient bits per cycle, used three times on 48-bit dividends)
// and the square root (one root bit per cycle). When the variance is not divided
// (first block of a series, or a variance that clamps to zero) the divide and
// square root are skipped. A refused beat goes from idle straight to the done
// state. A finished result waits in the output register, and the next beat is
// taken while it waits.
module running_block_average_error_unit import rbae_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     first_block_i,
  input  logic signed [DATA_W-1:0] block_mean_i,
  input  logic [DATA_W-1:0]        block_mean_square_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] running_mean_o,
  output logic [DATA_W-1:0]        mean_error_o,
  output logic [COUNT_OUT_W-1:0]   block_count_o,
  output logic                     count_full_o
);

  rbae_state_e state_q, state_d;

  logic [SUM_W-1:0]       sum_mean_q, sum_mean_d;
  logic [SUM_W-1:0]       sum_sq_q, sum_sq_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DATA_W-1:0]      last_mean_q, last_mean_d;
  logic [DATA_W-1:0]      last_error_q, last_error_d;
  logic                   full_q, full_d;
  logic [DATA_W-1:0]      amag_q, amag_d;
  logic [DATA_W-1:0]      mean2_q, mean2_d;
  logic [PROD_W-1:0]      msq_q, msq_d;
  logic [VAR_W-1:0]       var_q, var_d;

  logic                   out_valid_q, out_valid_d;
  logic [DATA_W-1:0]      out_mean_q, out_error_q;
  logic [COUNT_OUT_W-1:0] out_count_q;
  logic                   out_full_q;

  logic                   in_accept, is_full, out_load, var_ok, mean_neg;
  logic                   div_start, div_done, sqrt_start, sqrt_done;
  logic [DIV_NUM_W-1:0]   div_num, div_quo, qcorr, mean_bits;
  logic [CNT_W-1:0]       div_den, div_rem;
  logic [ROOT_W-1:0]      sqrt_root;
  logic [SUM_W-1:0]       sum_mean_abs, bm_ext, bms_ext;
  logic [PROD_W-1:0]      m2s, var_diff;

  rbae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  rbae_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_quo[VAR_W-1:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign is_full   = !first_block_i && (cnt_q >= CNT_W'(MAX_BLOCKS));
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign bm_ext  = {{(SUM_W-DATA_W){block_mean_i[DATA_W-1]}}, block_mean_i};
  assign bms_ext = {{(SUM_W-DATA_W){1'b0}}, block_mean_square_i};

  // Floor division of a signed sum: divide the magnitude, round away on remainder
  assign mean_neg     = sum_mean_q[SUM_W-1];
  assign sum_mean_abs = mean_neg ? (~sum_mean_q + 1'b1) : sum_mean_q;
  assign qcorr        = div_quo + DIV_NUM_W'(mean_neg && (div_rem != '0));
  assign mean_bits    = mean_neg ? (~qcorr + 1'b1) : qcorr;

  assign m2s      = {{(PROD_W-DATA_W-FRAC_W){1'b0}}, mean2_q, {FRAC_W{1'b0}}};
  assign var_ok   = (cnt_q != CNT_W'(1)) && (m2s > msq_q);
  assign var_diff = m2s - msq_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = is_full ? ST_DONE : ST_MEAN_GO;
        end
      end
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_done) state_d = ST_SQ_GO;
      ST_SQ_GO:     state_d = ST_SQ_WAIT;
      ST_SQ_WAIT:   if (div_done) state_d = ST_MUL;
      ST_MUL:       state_d = ST_VAR;
      ST_VAR:       state_d = var_ok ? ST_VDIV_GO : ST_DONE;
      ST_VDIV_GO:   state_d = ST_VDIV_WAIT;
      ST_VDIV_WAIT: if (div_done) state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_d = ST_DONE;
      ST_DONE:      if (out_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    div_start  = 1'b0;
    div_num    = DIV_NUM_W'(sum_mean_abs);
    div_den    = cnt_q;
    sqrt_start = 1'b0;
    unique case (state_q)
      ST_MEAN_GO: begin
        div_start = 1'b1;
      end
      ST_SQ_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(sum_sq_q);
      end
      ST_VDIV_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(var_q);
        div_den   = cnt_q - 1'b1;
      end
      ST_VDIV_WAIT: begin
        sqrt_start = div_done;
      end
      default: begin
      end
    endcase
  end

  // Datapath
  always_comb begin
    sum_mean_d   = sum_mean_q;
    sum_sq_d     = sum_sq_q;
    cnt_d        = cnt_q;
    full_d       = full_q;
    last_mean_d  = last_mean_q;
    last_error_d = last_error_q;
    amag_d       = amag_q;
    mean2_d      = mean2_q;
    msq_d        = msq_q;
    var_d        = var_q;
    if (in_accept) begin
      full_d = is_full;
      if (!is_full) begin
        if (first_block_i) begin
          sum_mean_d = bm_ext;
          sum_sq_d   = bms_ext;
          cnt_d      = CNT_W'(1);
        end else begin
          sum_mean_d = sum_mean_q + bm_ext;
          sum_sq_d   = sum_sq_q + bms_ext;
          cnt_d      = cnt_q + 1'b1;
        end
      end
    end
    if ((state_q == ST_MEAN_WAIT) && div_done) begin
      last_mean_d = mean_bits[DATA_W-1:0];
      amag_d      = qcorr[DATA_W-1:0];
    end
    if ((state_q == ST_SQ_WAIT) && div_done) begin
      mean2_d = div_quo[DATA_W-1:0];
    end
    if (state_q == ST_MUL) begin
      msq_d = amag_q * amag_q;
    end
    if (state_q == ST_VAR) begin
      if (var_ok) begin
        var_d = var_diff[VAR_W-1:0];
      end else begin
        last_error_d = '0;
      end
    end
    if ((state_q == ST_SQRT_WAIT) && sqrt_done) begin
      last_error_d = DATA_W'(sqrt_root);
    end
  end

  // Hold the result until taken; drop valid on a completed beat
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sum_mean_q   <= '0;
      sum_sq_q     <= '0;
      cnt_q        <= '0;
      full_q       <= 1'b0;
      last_mean_q  <= '0;
      last_error_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sum_mean_q   <= sum_mean_d;
      sum_sq_q     <= sum_sq_d;
      cnt_q        <= cnt_d;
      full_q       <= full_d;
      last_mean_q  <= last_mean_d;
      last_error_q <= last_error_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amag_q  <= amag_d;
    mean2_q <= mean2_d;
    msq_q   <= msq_d;
    var_q   <= var_d;
    if (out_load) begin
      out_mean_q  <= last_mean_q;
      out_error_q <= last_error_q;
      out_count_q <= COUNT_OUT_W'(cnt_q);
      out_full_q  <= full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign running_mean_o = out_mean_q;
  assign mean_error_o   = out_error_q;
  assign block_count_o  = out_count_q;
  assign count_full_o   = out_full_q;

endmodule

// ===== hw/rtl/rbae_checker.sv =====
// Port-level assertions for the running block average unit, bound to the top.
`include "running_block_average_error_unit_macros.svh"

module rbae_checker import rbae_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     first_block_i,
  input logic signed [DATA_W-1:0] block_mean_i,
  input logic [DATA_W-1:0]        block_mean_square_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] running_mean_o,
  input logic [DATA_W-1:0]        mean_error_o,
  input logic [COUNT_OUT_W-1:0]   block_count_o,
  input logic                     count_full_o
);

  // One beat at a time: the unit is busy right after taking a beat
  `RBAE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  `RBAE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(running_mean_o) && $stable(mean_error_o) && $stable(block_count_o))

  // Root of a variance below 2^48 never reaches the top byte
  `RBAE_ASSERT_NOW(a_error_range, out_valid_o, mean_error_o[DATA_W-1:ROOT_W] == '0)

  // A refused beat reports the full count
  `RBAE_ASSERT_NOW(a_full_count, out_valid_o && count_full_o, block_count_o == COUNT_OUT_W'(MAX_BLOCKS))

endmodule

bind running_block_average_error_unit rbae_checker u_rbae_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the running block average and standard error unit.
module testbench import rbae_pkg::*; ();

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int MAX_REPORTS  = 40;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_HOLD
  } stall_mode_e;

  typedef struct {
    logic [DATA_W-1:0]      mean;
    logic [DATA_W-1:0]      err;
    logic [COUNT_OUT_W-1:0] count;
    logic                   full;
  } block_stats_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     first_block_i = 1'b0;
  logic signed [DATA_W-1:0] block_mean_i = '0;
  logic [DATA_W-1:0]        block_mean_square_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] running_mean_o;
  logic [DATA_W-1:0]        mean_error_o;
  logic [COUNT_OUT_W-1:0]   block_count_o;
  logic                     count_full_o;

  // Shadow of the unit's series state
  longint            mean_sum;
  logic [63:0]       square_sum;
  logic [31:0]       series_count;
  logic [DATA_W-1:0] held_mean;
  logic [DATA_W-1:0] held_error;

  block_stats_t expected_stats[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;

  running_block_average_error_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .first_block_i       (first_block_i),
    .block_mean_i        (block_mean_i),
    .block_mean_square_i (block_mean_square_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .running_mean_o      (running_mean_o),
    .mean_error_o        (mean_error_o),
    .block_count_o       (block_count_o),
    .count_full_o        (count_full_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic block_stats_t predict_stats(input logic first, input logic [31:0] mean_in,
                                                 input logic [31:0] sq_in);
    block_stats_t s;
    longint       n;
    longint       q;
    longint       mag;
    logic [63:0]  msq;
    logic [63:0]  scaled;
    logic [63:0]  root;
    // Refuse the beat once the series is full; a restart is always taken
    if (!first && series_count >= MAX_BLOCKS) begin
      s.mean  = held_mean;
      s.err   = held_error;
      s.count = series_count[COUNT_OUT_W-1:0];
      s.full  = 1'b1;
      return s;
    end
    if (first) begin
      mean_sum     = 0;
      square_sum   = '0;
      series_count = '0;
    end
    mean_sum     += longint'($signed(mean_in));
    square_sum   += {32'b0, sq_in};
    series_count += 1;
    n = longint'(series_count);
    q = mean_sum / n;
    if (mean_sum % n != 0 && mean_sum < 0) q -= 1;
    mag    = (q < 0) ? -q : q;
    msq    = mag * mag;
    scaled = (square_sum / n) << FRAC_W;
    root   = '0;
    if (n > 1 && scaled > msq) root = int_sqrt((scaled - msq) / (n - 1));
    held_mean  = q[31:0];
    held_error = root[31:0];
    s.mean  = held_mean;
    s.err   = held_error;
    s.count = series_count[COUNT_OUT_W-1:0];
    s.full  = 1'b0;
    return s;
  endfunction

  // Pick a plausible block around a series center: mean square at or above mean^2
  function automatic void pick_block(input int center, input int unsigned spread,
                                     output logic [31:0] mean, output logic [31:0] sq);
    logic signed [31:0] m;
    longint             base;
    m    = center + int'($urandom_range(0, 32'h1_0000)) - 32'sh8000;
    base = (longint'(m) * longint'(m)) >>> FRAC_W;
    mean = m;
    sq   = base[31:0] + $urandom_range(0, spread);
  endfunction

  function automatic int pick_center();
    return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch on %s: got %h, want %h", field, got, want);
    mismatch_count++;
  endtask

  task automatic send_block(input logic first, input logic [31:0] mean, input logic [31:0] sq);
    int   gap;
    logic stalled;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i          <= 1'b1;
    first_block_i       <= first;
    block_mean_i        <= mean;
    block_mean_square_i <= sq;
    // Sample stall mid-cycle so the value seen is the one at the next edge
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    expected_stats.push_back(predict_stats(first, mean, sq));
  endtask

  // Start without a first_block flag right after reset
  task automatic test_fresh_start();
    send_block(1'b0, 32'h0001_0000, 32'h0001_0000);
    send_block(1'b0, 32'h0003_0000, 32'h0009_0000);
  endtask

  task automatic test_field_extremes();
    send_block(1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
    send_block(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
    send_block(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(1'b1, 32'hFFFF_FFFF, 32'h0000_0001);
    send_block(1'b0, 32'h0000_0001, 32'h0000_0000);
    send_block(1'b0, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Mean square far below mean^2 drives the variance negative
  task automatic test_variance_clamp();
    send_block(1'b1, 32'h0040_0000, 32'h0001_0000);
    send_block(1'b0, 32'h0040_0000, 32'h0001_0000);
    send_block(1'b0, 32'hFFC0_0000, 32'h0000_0000);
  endtask

  task automatic test_series_restart();
    logic [31:0] mean;
    logic [31:0] sq;
    int          center;
    center = pick_center();
    for (int i = 0; i < 6; i++) begin
      pick_block(center, 32'h00FF_FFFF, mean, sq);
      send_block(i == 0 || i == 3, mean, sq);
    end
  endtask

  // Fill a series to the limit, hit it, then restart while full
  task automatic test_series_full();
    logic [31:0] mean;
    logic [31:0] sq;
    int          center;
    center = pick_center();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      pick_block(center, 32'h0FFF_FFFF, mean, sq);
      send_block(i == 0, mean, sq);
    end
    for (int i = 0; i < 12; i++) send_block(1'b0, $urandom(), $urandom());
    pick_block(center, 32'h000F_FFFF, mean, sq);
    send_block(1'b1, mean, sq);
    for (int i = 0; i < 3; i++) begin
      pick_block(center, 32'h000F_FFFF, mean, sq);
      send_block(1'b0, mean, sq);
    end
  endtask

  task automatic test_random_series();
    logic [31:0] mean;
    logic [31:0] sq;
    int          center;
    int unsigned spread;
    int          len;
    int          sent;
    sent = 0;
    while (sent < 240) begin
      center = pick_center();
      spread = 1 << $urandom_range(0, 28);
      len    = $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: raw fields and a stray restart now and then
          send_block($urandom_range(0, 3) == 0, $urandom(), $urandom());
        end else begin
          pick_block(center, spread, mean, sq);
          send_block(i == 0 && $urandom_range(0, 7) != 0, mean, sq);
        end
        sent++;
      end
    end
  endtask

  // Receiver stall pattern, independent of the sender
  initial begin : stall_pattern
    stall_mode_e mode;
    int          span;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(1, 48);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // Check mid-cycle: the values seen here are the ones taken at the next edge
  always @(negedge clk_i) begin
    block_stats_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected beat", running_mean_o, 32'h0);
      end else begin
        want = expected_stats.pop_front();
        if (running_mean_o !== want.mean) report_mismatch("running_mean", running_mean_o, want.mean);
        if (mean_error_o !== want.err) report_mismatch("mean_error", mean_error_o, want.err);
        if (block_count_o !== want.count)
          report_mismatch("block_count", 32'(block_count_o), 32'(want.count));
        if (count_full_o !== want.full)
          report_mismatch("count_full", 32'(count_full_o), 32'(want.full));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_stats.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    mean_sum     = 0;
    square_sum   = '0;
    series_count = '0;
    held_mean    = '0;
    held_error   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fresh_start();
    test_field_extremes();
    test_variance_clamp();
    test_series_restart();
    test_series_full();
    test_random_series();

    in_valid_i <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rbae_pkg.sv
hw/rtl/rbae_div.sv
hw/rtl/rbae_sqrt.sv
hw/rtl/running_block_average_error_unit.sv
hw/rtl/rbae_checker.sv
test/testbench.sv
